[hw/rtl/four_sum_quadruplet_search_macros.svh]
// ----------------------------------------------------------------------------
// Four-sum quadruplet search: assertion macros
// Shared concurrent assertion forms for the block's modules.
// ----------------------------------------------------------------------------
`ifndef FOUR_SUM_QUADRUPLET_SEARCH_MACROS_SVH
`define FOUR_SUM_QUADRUPLET_SEARCH_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FSQ_ASSERT_NOW(label, clk, rst, ante, cons) \
label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
   else $error("four sum search: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FSQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
   else $error("four sum search: next-cycle check failed");

`endif

[hw/rtl/fsq_pkg.sv]
// ----------------------------------------------------------------------------
// Four-sum quadruplet search package
// Widths, operation and status codes, datapath commands and status flags.
// ----------------------------------------------------------------------------
package fsq_pkg;

   localparam int MaxItemsDefault = 64;
   localparam int DataWidth       = 32;
   localparam int SumWidth        = 34;

   // Operation codes carried on the request tuser.
   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_FETCH = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_NOP   = 2'd3;

   // Status codes carried on the response tuser.
   localparam logic [1:0] ST_FOUND    = 2'd0;
   localparam logic [1:0] ST_FINISHED = 2'd1;
   localparam logic [1:0] ST_ACCEPTED = 2'd2;
   localparam logic [1:0] ST_DROPPED  = 2'd3;

   // Register map.
   localparam logic REG_TARGET_SUM = 1'b0;

   typedef logic [4:0] cmd_type;

   // Commands from the controller to the datapath, one per cycle.
   localparam cmd_type CMD_NONE        = 5'd0;
   localparam cmd_type CMD_RESTART     = 5'd1;
   localparam cmd_type CMD_CLEAR       = 5'd2;
   localparam cmd_type CMD_INS_START   = 5'd3;
   localparam cmd_type CMD_INS_READ    = 5'd4;
   localparam cmd_type CMD_INS_SHIFT   = 5'd5;
   localparam cmd_type CMD_INS_PLACE   = 5'd6;
   localparam cmd_type CMD_START       = 5'd7;
   localparam cmd_type CMD_FINISH      = 5'd8;
   localparam cmd_type CMD_READ_AB     = 5'd9;
   localparam cmd_type CMD_LATCH_AB    = 5'd10;
   localparam cmd_type CMD_READ_CD     = 5'd11;
   localparam cmd_type CMD_SUM         = 5'd12;
   localparam cmd_type CMD_LO_INC      = 5'd13;
   localparam cmd_type CMD_HI_DEC      = 5'd14;
   localparam cmd_type CMD_READ_LNEXT  = 5'd15;
   localparam cmd_type CMD_READ_HPREV  = 5'd16;
   localparam cmd_type CMD_STEP        = 5'd17;
   localparam cmd_type CMD_J_INIT      = 5'd18;
   localparam cmd_type CMD_READ_J      = 5'd19;
   localparam cmd_type CMD_J_INC       = 5'd20;
   localparam cmd_type CMD_J_TAKE      = 5'd21;
   localparam cmd_type CMD_I_INIT      = 5'd22;
   localparam cmd_type CMD_I_TAKE      = 5'd23;
   localparam cmd_type CMD_EMIT_Q      = 5'd24;
   localparam cmd_type CMD_EMIT_Z      = 5'd25;

   // Flags from the datapath back to the controller.
   typedef struct packed {
      logic full;
      logic lt4;
      logic p_zero;
      logic ins_greater;
      logic lo_lt_hi;
      logic sum_eq;
      logic sum_lt;
      logic lnext_eq;
      logic hprev_eq;
      logic j_in;
      logic i_in;
      logic j_dup;
      logic i_dup;
      logic started;
      logic finished;
   } dp_status_type;

endpackage

[hw/rtl/fsq_datapath.sv]
// ----------------------------------------------------------------------------
// Four-sum search datapath
// Sorted value store, search indices, sum unit and result word registers.
// ----------------------------------------------------------------------------
module fsq_datapath #(
   parameter int MaxItems = fsq_pkg::MaxItemsDefault
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  fsq_pkg::cmd_type                      cmd,
   input  logic signed [fsq_pkg::DataWidth-1:0]  req_value,
   input  logic signed [fsq_pkg::DataWidth-1:0]  target_sum,
   output fsq_pkg::dp_status_type                status,
   output logic signed [fsq_pkg::DataWidth-1:0]  first_value,
   output logic signed [fsq_pkg::DataWidth-1:0]  second_value,
   output logic signed [fsq_pkg::DataWidth-1:0]  third_value,
   output logic signed [fsq_pkg::DataWidth-1:0]  fourth_value
);

   `include "four_sum_quadruplet_search_macros.svh"

   localparam int IW = $clog2(MaxItems);
   localparam int CW = $clog2(MaxItems + 1);
   localparam int DW = fsq_pkg::DataWidth;
   localparam int SW = fsq_pkg::SumWidth;

   logic [DW-1:0] mem [MaxItems];

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] p_ff, p_in;
   logic [CW-1:0] oi_ff, oi_in;
   logic [CW-1:0] si_ff, si_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [CW-1:0] k_ff, k_in;
   logic          started_ff, started_in;
   logic          finished_ff, finished_in;

   logic signed [DW-1:0] v_ff, v_in;
   logic signed [DW-1:0] a_ff, a_in;
   logic signed [DW-1:0] b_ff, b_in;
   logic signed [DW-1:0] c_ff, c_in;
   logic signed [DW-1:0] d_ff, d_in;
   logic signed [SW-1:0] sum_ff, sum_in;
   logic signed [DW-1:0] rd_a_ff, rd_b_ff;
   logic signed [DW-1:0] q0_ff, q1_ff, q2_ff, q3_ff;

   logic [CW-1:0] addr_a, addr_b;
   logic          we;
   logic [CW-1:0] waddr;
   logic [DW-1:0] wdata;
   logic [CW-1:0] last_idx;
   logic signed [SW-1:0] target_ext;

   assign last_idx   = count_ff - CW'(1);
   assign target_ext = SW'(target_sum);

   // Read addresses and the store write port follow the command.
   always_comb begin
      addr_a = '0;
      addr_b = '0;
      we     = 1'b0;
      waddr  = p_ff;
      wdata  = v_ff;
      case (cmd)
         fsq_pkg::CMD_INS_READ:   addr_a = p_ff - CW'(1);
         fsq_pkg::CMD_INS_SHIFT: begin
            we    = 1'b1;
            wdata = rd_a_ff;
         end
         fsq_pkg::CMD_INS_PLACE:  we = 1'b1;
         fsq_pkg::CMD_READ_AB: begin
            addr_a = oi_ff;
            addr_b = si_ff;
         end
         fsq_pkg::CMD_READ_CD: begin
            addr_a = lo_ff;
            addr_b = hi_ff;
         end
         fsq_pkg::CMD_READ_LNEXT: addr_b = lo_ff + CW'(1);
         fsq_pkg::CMD_READ_HPREV: addr_b = hi_ff - CW'(1);
         fsq_pkg::CMD_READ_J: begin
            addr_a = k_ff;
            addr_b = k_ff - CW'(1);
         end
         default: ;
      endcase
   end

   // Value store with registered read data.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr[IW-1:0]] <= wdata;
      end
      rd_a_ff <= mem[addr_a[IW-1:0]];
      rd_b_ff <= mem[addr_b[IW-1:0]];
   end

   // Next values of the index and operand registers.
   always_comb begin
      count_in    = count_ff;
      p_in        = p_ff;
      oi_in       = oi_ff;
      si_in       = si_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      k_in        = k_ff;
      started_in  = started_ff;
      finished_in = finished_ff;
      v_in        = v_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      c_in        = c_ff;
      d_in        = d_ff;
      sum_in      = sum_ff;
      case (cmd)
         fsq_pkg::CMD_RESTART, fsq_pkg::CMD_CLEAR, fsq_pkg::CMD_INS_START: begin
            oi_in       = '0;
            si_in       = '0;
            lo_in       = '0;
            hi_in       = '0;
            started_in  = 1'b0;
            finished_in = 1'b0;
            if (cmd == fsq_pkg::CMD_CLEAR) begin
               count_in = '0;
            end
            if (cmd == fsq_pkg::CMD_INS_START) begin
               v_in = req_value;
               p_in = count_ff;
            end
         end
         fsq_pkg::CMD_INS_SHIFT: p_in = p_ff - CW'(1);
         fsq_pkg::CMD_INS_PLACE: count_in = count_ff + CW'(1);
         fsq_pkg::CMD_START: begin
            started_in = 1'b1;
            oi_in      = '0;
            si_in      = CW'(1);
            lo_in      = CW'(2);
            hi_in      = last_idx;
         end
         fsq_pkg::CMD_FINISH: begin
            started_in  = 1'b1;
            finished_in = 1'b1;
         end
         fsq_pkg::CMD_LATCH_AB: begin
            a_in = rd_a_ff;
            b_in = rd_b_ff;
         end
         fsq_pkg::CMD_SUM: begin
            c_in   = rd_a_ff;
            d_in   = rd_b_ff;
            sum_in = SW'(a_ff) + SW'(b_ff) + SW'(rd_a_ff) + SW'(rd_b_ff);
         end
         fsq_pkg::CMD_LO_INC: lo_in = lo_ff + CW'(1);
         fsq_pkg::CMD_HI_DEC: hi_in = hi_ff - CW'(1);
         fsq_pkg::CMD_STEP: begin
            lo_in = lo_ff + CW'(1);
            hi_in = hi_ff - CW'(1);
         end
         fsq_pkg::CMD_J_INIT: k_in = si_ff + CW'(1);
         fsq_pkg::CMD_I_INIT: k_in = oi_ff + CW'(1);
         fsq_pkg::CMD_J_INC:  k_in = k_ff + CW'(1);
         fsq_pkg::CMD_J_TAKE: begin
            si_in = k_ff;
            b_in  = rd_a_ff;
            lo_in = k_ff + CW'(1);
            hi_in = last_idx;
         end
         fsq_pkg::CMD_I_TAKE: begin
            oi_in = k_ff;
            si_in = k_ff + CW'(1);
            lo_in = k_ff + CW'(2);
            hi_in = last_idx;
         end
         default: ;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         oi_ff       <= '0;
         si_ff       <= '0;
         lo_ff       <= '0;
         hi_ff       <= '0;
         started_ff  <= 1'b0;
         finished_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         oi_ff       <= oi_in;
         si_ff       <= si_in;
         lo_ff       <= lo_in;
         hi_ff       <= hi_in;
         started_ff  <= started_in;
         finished_ff <= finished_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      p_ff   <= p_in;
      k_ff   <= k_in;
      v_ff   <= v_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      sum_ff <= sum_in;
      if (cmd == fsq_pkg::CMD_EMIT_Q) begin
         q0_ff <= a_ff;
         q1_ff <= b_ff;
         q2_ff <= c_ff;
         q3_ff <= d_ff;
      end else if (cmd == fsq_pkg::CMD_EMIT_Z) begin
         q0_ff <= '0;
         q1_ff <= '0;
         q2_ff <= '0;
         q3_ff <= '0;
      end
   end

   assign first_value  = q0_ff;
   assign second_value = q1_ff;
   assign third_value  = q2_ff;
   assign fourth_value = q3_ff;

   // Flags for the controller.
   always_comb begin
      status.full        = (count_ff == CW'(MaxItems));
      status.lt4         = (count_ff < CW'(4));
      status.p_zero      = (p_ff == '0);
      status.ins_greater = (rd_a_ff > v_ff);
      status.lo_lt_hi    = (lo_ff < hi_ff);
      status.sum_eq      = (sum_ff == target_ext);
      status.sum_lt      = (sum_ff < target_ext);
      status.lnext_eq    = (rd_b_ff == c_ff);
      status.hprev_eq    = (rd_b_ff == d_ff);
      status.j_in        = (({1'b0, k_ff} + (CW + 1)'(2)) < {1'b0, count_ff});
      status.i_in        = (({1'b0, k_ff} + (CW + 1)'(3)) < {1'b0, count_ff});
      status.j_dup       = ({1'b0, k_ff} > ({1'b0, oi_ff} + (CW + 1)'(1)))
                           && (rd_a_ff == rd_b_ff);
      status.i_dup       = (rd_a_ff == rd_b_ff);
      status.started     = started_ff;
      status.finished    = finished_ff;
   end

   // The fill count never passes the store depth.
   `FSQ_ASSERT_NOW(a_count_range, clock, reset, 1'b1, count_ff <= CW'(MaxItems))
   // A finished search has always been started.
   `FSQ_ASSERT_NOW(a_finish_started, clock, reset, finished_ff, started_ff)
   // Placing a value grows the store by exactly one.
   `FSQ_ASSERT_NEXT(a_place_count, clock, reset, cmd == fsq_pkg::CMD_INS_PLACE,
      count_ff == CW'($past(count_ff) + CW'(1)))

endmodule

[hw/rtl/fsq_ctrl.sv]
// ----------------------------------------------------------------------------
// Four-sum search controller
// Sequences insertion, the resumable search and the response word.
// ----------------------------------------------------------------------------
module fsq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [1:0]             req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [1:0]             rsp_tuser,
   output fsq_pkg::cmd_type       cmd,
   input  fsq_pkg::dp_status_type status
);

   localparam logic [4:0] S_IDLE       = 5'd0;
   localparam logic [4:0] S_INS_LOOP   = 5'd1;
   localparam logic [4:0] S_INS_CMP    = 5'd2;
   localparam logic [4:0] S_RD_AB      = 5'd3;
   localparam logic [4:0] S_LATCH_AB   = 5'd4;
   localparam logic [4:0] S_SCAN       = 5'd5;
   localparam logic [4:0] S_SUM        = 5'd6;
   localparam logic [4:0] S_CMP        = 5'd7;
   localparam logic [4:0] S_SKIP_L     = 5'd8;
   localparam logic [4:0] S_SKIP_L_CMP = 5'd9;
   localparam logic [4:0] S_SKIP_H     = 5'd10;
   localparam logic [4:0] S_SKIP_H_CMP = 5'd11;
   localparam logic [4:0] S_J_CHECK    = 5'd12;
   localparam logic [4:0] S_J_CMP      = 5'd13;
   localparam logic [4:0] S_I_CHECK    = 5'd14;
   localparam logic [4:0] S_I_CMP      = 5'd15;
   localparam logic [4:0] S_DONE       = 5'd16;

   logic [4:0] state_ff, state_in;
   logic [1:0] st_ff, st_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_fire;
   logic       emit;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;

   // State sequencing and command issue.
   always_comb begin
      state_in = state_ff;
      st_in    = st_ff;
      cmd      = fsq_pkg::CMD_NONE;
      emit     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_tuser)
                  fsq_pkg::OP_LOAD: begin
                     if (status.full) begin
                        cmd      = fsq_pkg::CMD_RESTART;
                        st_in    = fsq_pkg::ST_DROPPED;
                        state_in = S_DONE;
                     end else begin
                        cmd      = fsq_pkg::CMD_INS_START;
                        state_in = S_INS_LOOP;
                     end
                  end
                  fsq_pkg::OP_FETCH: begin
                     if (status.finished) begin
                        st_in    = fsq_pkg::ST_FINISHED;
                        state_in = S_DONE;
                     end else if (!status.started) begin
                        if (status.lt4) begin
                           cmd      = fsq_pkg::CMD_FINISH;
                           st_in    = fsq_pkg::ST_FINISHED;
                           state_in = S_DONE;
                        end else begin
                           cmd      = fsq_pkg::CMD_START;
                           state_in = S_RD_AB;
                        end
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  fsq_pkg::OP_CLEAR: begin
                     cmd      = fsq_pkg::CMD_CLEAR;
                     st_in    = fsq_pkg::ST_ACCEPTED;
                     state_in = S_DONE;
                  end
                  default: ;
               endcase
            end
         end
         // Sorted insertion: shift larger entries up one slot at a time.
         S_INS_LOOP: begin
            if (status.p_zero) begin
               cmd      = fsq_pkg::CMD_INS_PLACE;
               st_in    = fsq_pkg::ST_ACCEPTED;
               state_in = S_DONE;
            end else begin
               cmd      = fsq_pkg::CMD_INS_READ;
               state_in = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            if (status.ins_greater) begin
               cmd      = fsq_pkg::CMD_INS_SHIFT;
               state_in = S_INS_LOOP;
            end else begin
               cmd      = fsq_pkg::CMD_INS_PLACE;
               st_in    = fsq_pkg::ST_ACCEPTED;
               state_in = S_DONE;
            end
         end
         // Fetch the two outer values.
         S_RD_AB: begin
            cmd      = fsq_pkg::CMD_READ_AB;
            state_in = S_LATCH_AB;
         end
         S_LATCH_AB: begin
            cmd      = fsq_pkg::CMD_LATCH_AB;
            state_in = S_SCAN;
         end
         // Two-pointer scan.
         S_SCAN: begin
            if (status.lo_lt_hi) begin
               cmd      = fsq_pkg::CMD_READ_CD;
               state_in = S_SUM;
            end else begin
               cmd      = fsq_pkg::CMD_J_INIT;
               state_in = S_J_CHECK;
            end
         end
         S_SUM: begin
            cmd      = fsq_pkg::CMD_SUM;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (status.sum_eq) begin
               state_in = S_SKIP_L;
            end else if (status.sum_lt) begin
               cmd      = fsq_pkg::CMD_LO_INC;
               state_in = S_SCAN;
            end else begin
               cmd      = fsq_pkg::CMD_HI_DEC;
               state_in = S_SCAN;
            end
         end
         // Step past repeats of the third and fourth values.
         S_SKIP_L: begin
            if (status.lo_lt_hi) begin
               cmd      = fsq_pkg::CMD_READ_LNEXT;
               state_in = S_SKIP_L_CMP;
            end else begin
               state_in = S_SKIP_H;
            end
         end
         S_SKIP_L_CMP: begin
            if (status.lnext_eq) begin
               cmd      = fsq_pkg::CMD_LO_INC;
               state_in = S_SKIP_L;
            end else begin
               state_in = S_SKIP_H;
            end
         end
         S_SKIP_H: begin
            if (status.lo_lt_hi) begin
               cmd      = fsq_pkg::CMD_READ_HPREV;
               state_in = S_SKIP_H_CMP;
            end else begin
               cmd      = fsq_pkg::CMD_STEP;
               st_in    = fsq_pkg::ST_FOUND;
               state_in = S_DONE;
            end
         end
         S_SKIP_H_CMP: begin
            if (status.hprev_eq) begin
               cmd      = fsq_pkg::CMD_HI_DEC;
               state_in = S_SKIP_H;
            end else begin
               cmd      = fsq_pkg::CMD_STEP;
               st_in    = fsq_pkg::ST_FOUND;
               state_in = S_DONE;
            end
         end
         // Advance the second index past repeated values.
         S_J_CHECK: begin
            if (status.j_in) begin
               cmd      = fsq_pkg::CMD_READ_J;
               state_in = S_J_CMP;
            end else begin
               cmd      = fsq_pkg::CMD_I_INIT;
               state_in = S_I_CHECK;
            end
         end
         S_J_CMP: begin
            if (status.j_dup) begin
               cmd      = fsq_pkg::CMD_J_INC;
               state_in = S_J_CHECK;
            end else begin
               cmd      = fsq_pkg::CMD_J_TAKE;
               state_in = S_SCAN;
            end
         end
         // Advance the first index past repeated values.
         S_I_CHECK: begin
            if (status.i_in) begin
               cmd      = fsq_pkg::CMD_READ_J;
               state_in = S_I_CMP;
            end else begin
               cmd      = fsq_pkg::CMD_FINISH;
               st_in    = fsq_pkg::ST_FINISHED;
               state_in = S_DONE;
            end
         end
         S_I_CMP: begin
            if (status.i_dup) begin
               cmd      = fsq_pkg::CMD_J_INC;
               state_in = S_I_CHECK;
            end else begin
               cmd      = fsq_pkg::CMD_I_TAKE;
               state_in = S_RD_AB;
            end
         end
         // Load the response word once the output slot is free.
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               emit     = 1'b1;
               cmd      = (st_ff == fsq_pkg::ST_FOUND) ? fsq_pkg::CMD_EMIT_Q
                                                       : fsq_pkg::CMD_EMIT_Z;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Response word handshake.
   always_comb begin
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = st_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      st_ff         <= st_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

[hw/rtl/four_sum_quadruplet_search.sv]
// A clear or a dropped load goes straight to the response; a load reads and
// shifts each larger stored value up one slot, then places the new one. A
// fetch reads, sums and compares per two-pointer step, and reads and compares
// per skipped repeat, the store reads being registered. One word in flight;
// the next word is taken once the previous one sits in the response register.
// Reset empties the store and search state; contents stay and need no clearing.
// ----------------------------------------------------------------------------
// Four-sum quadruplet search
// Sorted value store with a resumable four-sum search and a register port.
// ----------------------------------------------------------------------------
module four_sum_quadruplet_search #(
   parameter int MaxItems = fsq_pkg::MaxItemsDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // value[31:0]
   input  logic [1:0]   req_tuser,   // op[1:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // first, second, third, fourth value
   output logic [1:0]   rsp_tuser,   // status[1:0]
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [0:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   fsq_pkg::cmd_type       cmd;
   fsq_pkg::dp_status_type status;
   logic signed [31:0]     target_sum_ff;
   logic signed [31:0]     first_value, second_value, third_value, fourth_value;

   // Register port: single target register, always ready.
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[0] == fsq_pkg::REG_TARGET_SUM) ? target_sum_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_sum_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[0] == fsq_pkg::REG_TARGET_SUM) begin
         target_sum_ff <= csr_pwdata;
      end
   end

   fsq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .status     (status)
   );

   fsq_datapath #(
      .MaxItems (MaxItems)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_value    (req_tdata),
      .target_sum   (target_sum_ff),
      .status       (status),
      .first_value  (first_value),
      .second_value (second_value),
      .third_value  (third_value),
      .fourth_value (fourth_value)
   );

   assign rsp_tdata = {fourth_value, third_value, second_value, first_value};

endmodule
